@@ sv/tlfq_pkg.sv @@
package tlfq_pkg;

	// APB register map: one 32-bit word for each quantum.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REG_QUANTUM0 = 1'b0;
	localparam logic REG_QUANTUM1 = 1'b1;

	localparam logic [15:0] QUANTUM0_RESET = 16'd8;
	localparam logic [15:0] QUANTUM1_RESET = 16'd16;

	localparam logic CMD_ARRIVE   = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_DROP0 = 2'd1,
		STAT_DROP1 = 2'd2,
		STAT_IDLE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] rem;
	} entry_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic start;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

@@ sv/tlfq_ctrl.sv @@
module tlfq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tlfq_pkg::dp_status_t dp_status,
	output tlfq_pkg::ctrl_cmd_t  dp_cmd
);
	import tlfq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				// The commit waits until the output register can take the word.
				if (dp_status.out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		dp_cmd.start  = 1'b0;
		dp_cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				dp_cmd.start = in_valid;
			end
			S_EXEC: begin
				dp_cmd.commit = dp_status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ sv/tlfq_dp.sv @@
module tlfq_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlfq_pkg::ctrl_cmd_t  dp_cmd,
	output tlfq_pkg::dp_status_t dp_status,
	input  logic [15:0]          quantum_level0,
	input  logic [15:0]          quantum_level1,
	input  logic                 command,
	input  logic [7:0]           job_id,
	input  logic [15:0]          burst_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [7:0]           served_id,
	output logic                 served_level,
	output logic [15:0]          slice_length,
	output logic                 job_finished,
	output logic [31:0]          end_time
);
	import tlfq_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
	localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_IDX  = PW'(QUEUE_DEPTH - 1);

	entry_t mem0 [QUEUE_DEPTH];
	entry_t mem1 [QUEUE_DEPTH];

	logic [PW-1:0] head0_q, head1_q;
	logic [CW-1:0] cnt0_q, cnt1_q;
	logic [31:0]   elapsed_q;

	logic          cmd_q;
	logic [7:0]    id_q;
	logic [15:0]   burst_q;
	entry_t        rd0_q, rd1_q;

	logic          out_valid_q;
	status_t       status_q;
	logic [7:0]    served_id_q;
	logic          served_level_q;
	logic [15:0]   slice_q;
	logic          finished_q;
	logic [31:0]   end_time_q;

	logic [SW-1:0] sum0, sum1;
	logic [PW-1:0] tail0, tail1;
	logic [PW-1:0] head0_inc, head1_inc;

	logic          has0, has1, run;
	logic          sel_lvl;
	entry_t        sel_e;
	logic [15:0]   sel_q;
	logic          fin;
	logic [15:0]   slice;
	logic [15:0]   rem_left;

	logic          wr0, wr1;
	entry_t        wr0_data, wr1_data;
	logic [PW-1:0] head0_d, head1_d;
	logic [CW-1:0] cnt0_d, cnt1_d;
	status_t       stat_d;

	// Tail index is head plus count, folded back into the ring.
	assign sum0  = SW'(head0_q) + SW'(cnt0_q);
	assign sum1  = SW'(head1_q) + SW'(cnt1_q);
	assign tail0 = (sum0 >= DEPTH_SUM) ? PW'(sum0 - DEPTH_SUM) : PW'(sum0);
	assign tail1 = (sum1 >= DEPTH_SUM) ? PW'(sum1 - DEPTH_SUM) : PW'(sum1);

	assign head0_inc = (head0_q == LAST_IDX) ? '0 : head0_q + 1'b1;
	assign head1_inc = (head1_q == LAST_IDX) ? '0 : head1_q + 1'b1;

	assign has0    = (cnt0_q != '0);
	assign has1    = (cnt1_q != '0);
	assign sel_lvl = !has0;
	assign sel_e   = has0 ? rd0_q : rd1_q;
	assign sel_q   = has0 ? quantum_level0 : quantum_level1;
	assign run     = (cmd_q == CMD_DISPATCH) && (has0 || has1);
	assign fin     = (sel_e.rem <= sel_q);
	assign slice   = fin ? sel_e.rem : sel_q;
	assign rem_left = sel_e.rem - sel_q;

	always_comb begin
		wr0      = 1'b0;
		wr1      = 1'b0;
		wr0_data = '{id: id_q, rem: burst_q};
		wr1_data = '{id: sel_e.id, rem: rem_left};
		head0_d  = head0_q;
		head1_d  = head1_q;
		cnt0_d   = cnt0_q;
		cnt1_d   = cnt1_q;
		stat_d   = STAT_OK;
		if (cmd_q == CMD_ARRIVE) begin
			if (cnt0_q == FULL_CNT) begin
				stat_d = STAT_DROP0;
			end else begin
				wr0    = 1'b1;
				cnt0_d = cnt0_q + 1'b1;
			end
		end else if (has0) begin
			head0_d = head0_inc;
			cnt0_d  = cnt0_q - 1'b1;
			if (!fin) begin
				if (cnt1_q == FULL_CNT) begin
					stat_d = STAT_DROP1;
				end else begin
					wr1    = 1'b1;
					cnt1_d = cnt1_q + 1'b1;
				end
			end
		end else if (has1) begin
			// A level-1 job is popped before it is pushed back, so the old
			// head-plus-count slot is the new tail and the count holds.
			head1_d = head1_inc;
			if (fin) begin
				cnt1_d = cnt1_q - 1'b1;
			end else begin
				wr1 = 1'b1;
			end
		end else begin
			stat_d = STAT_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			cmd_q   <= command;
			id_q    <= job_id;
			burst_q <= burst_length;
			rd0_q   <= mem0[head0_q];
			rd1_q   <= mem1[head1_q];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit && wr0) begin
			mem0[tail0] <= wr0_data;
		end
		if (dp_cmd.commit && wr1) begin
			mem1[tail1] <= wr1_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head0_q   <= '0;
			head1_q   <= '0;
			cnt0_q    <= '0;
			cnt1_q    <= '0;
			elapsed_q <= '0;
		end else if (dp_cmd.commit) begin
			head0_q <= head0_d;
			head1_q <= head1_d;
			cnt0_q  <= cnt0_d;
			cnt1_q  <= cnt1_d;
			if (run) begin
				elapsed_q <= elapsed_q + 32'(slice);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			status_q       <= stat_d;
			served_id_q    <= run ? sel_e.id : 8'd0;
			served_level_q <= run ? sel_lvl : 1'b0;
			slice_q        <= run ? slice : 16'd0;
			finished_q     <= run && fin;
			end_time_q     <= run ? elapsed_q + 32'(slice) : elapsed_q;
		end
	end

	assign dp_status.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign served_id    = served_id_q;
	assign served_level = served_level_q;
	assign slice_length = slice_q;
	assign job_finished = finished_q;
	assign end_time     = end_time_q;

endmodule

@@ sv/two_level_feedback_queue_scheduler.sv @@
// An accepted input word is registered together with the read of the queue memories;
// the commit then updates the memories and registers the result word. No new input
// word is taken until that commit, and a result word that waits on out_ready holds
// back the commit, and with it the next input word.
// Reset clears the queue pointers and counts, elapsed time and the handshake state,
// and loads the quanta with 8 and 16; the queue memories are not cleared.
module two_level_feedback_queue_scheduler #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlfq_pkg::ADDR_W-1:0]   paddr,
	input  logic [tlfq_pkg::DATA_W-1:0]   pwdata,
	output logic [tlfq_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [7:0]                    job_id,
	input  logic [15:0]                   burst_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [7:0]                    served_id,
	output logic                          served_level,
	output logic [15:0]                   slice_length,
	output logic                          job_finished,
	output logic [31:0]                   end_time
);
	import tlfq_pkg::*;

	logic [15:0] quantum0_q;
	logic [15:0] quantum1_q;
	logic        reg_sel;
	logic        wr_en;
	ctrl_cmd_t   dp_cmd;
	dp_status_t  dp_status;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum0_q <= QUANTUM0_RESET;
			quantum1_q <= QUANTUM1_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_QUANTUM0: quantum0_q <= pwdata[15:0];
				REG_QUANTUM1: quantum1_q <= pwdata[15:0];
				default:      quantum0_q <= quantum0_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_QUANTUM0: prdata = DATA_W'(quantum0_q);
			REG_QUANTUM1: prdata = DATA_W'(quantum1_q);
			default:      prdata = '0;
		endcase
	end

	tlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	tlfq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.dp_status      (dp_status),
		.quantum_level0 (quantum0_q),
		.quantum_level1 (quantum1_q),
		.command        (command),
		.job_id         (job_id),
		.burst_length   (burst_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.served_id      (served_id),
		.served_level   (served_level),
		.slice_length   (slice_length),
		.job_finished   (job_finished),
		.end_time       (end_time)
	);

endmodule

@@ bench/two_level_feedback_queue_scheduler_test.sv @@
module two_level_feedback_queue_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tlfq_pkg::*;

	localparam int QUEUE_SLOTS = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		status_t     status;
		logic [7:0]  id;
		logic        level;
		logic [15:0] length;
		logic        finished;
		logic [31:0] end_time;
	} slice_t;

	// Scheduler shadow: two job FIFOs, the elapsed time and both quanta, plus the
	// slices still owed by the block in the order their words were accepted.
	class slice_scoreboard;
		entry_t      level0_jobs[$];
		entry_t      level1_jobs[$];
		logic [31:0] elapsed;
		logic [15:0] quantum_l0;
		logic [15:0] quantum_l1;
		slice_t      owed_slices[$];
		int          errors;

		function new();
			elapsed    = '0;
			quantum_l0 = QUANTUM0_RESET;
			quantum_l1 = QUANTUM1_RESET;
			errors     = 0;
		endfunction

		function void set_quantum(logic idx, logic [15:0] value);
			if (idx == REG_QUANTUM0)
				quantum_l0 = value;
			else
				quantum_l1 = value;
		endfunction

		function int outstanding();
			return owed_slices.size();
		endfunction

		function void note_word(logic cmd, logic [7:0] id, logic [15:0] burst);
			slice_t      s;
			entry_t      job;
			logic [15:0] q;
			s = '0;
			s.status = STAT_OK;
			if (cmd == CMD_ARRIVE) begin
				job.id  = id;
				job.rem = burst;
				if (level0_jobs.size() < QUEUE_SLOTS)
					level0_jobs.push_back(job);
				else
					s.status = STAT_DROP0;
			end else if (level0_jobs.size() == 0 && level1_jobs.size() == 0) begin
				s.status = STAT_IDLE;
			end else begin
				if (level0_jobs.size() != 0) begin
					job     = level0_jobs.pop_front();
					s.level = 1'b0;
					q       = quantum_l0;
				end else begin
					job     = level1_jobs.pop_front();
					s.level = 1'b1;
					q       = quantum_l1;
				end
				s.id = job.id;
				if (job.rem <= q) begin
					s.length   = job.rem;
					s.finished = 1'b1;
				end else begin
					s.length = q;
					job.rem  = job.rem - q;
					// A popped level-1 job leaves room for itself, so only a demotion can overflow.
					if (level1_jobs.size() < QUEUE_SLOTS)
						level1_jobs.push_back(job);
					else
						s.status = STAT_DROP1;
				end
				elapsed = elapsed + 32'(s.length);
			end
			s.end_time = elapsed;
			owed_slices.push_back(s);
		endfunction

		function void check_slice(slice_t got);
			slice_t want;
			if (owed_slices.size() == 0) begin
				$error("result word with no expectation waiting: status %0d id %0d",
					got.status, got.id);
				errors++;
				return;
			end
			want = owed_slices.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.id !== want.id) begin
				$error("served_id: expected %0d, got %0d", want.id, got.id);
				errors++;
			end
			if (got.level !== want.level) begin
				$error("served_level: expected %0d, got %0d", want.level, got.level);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("slice_length: expected %0d, got %0d", want.length, got.length);
				errors++;
			end
			if (got.finished !== want.finished) begin
				$error("job_finished: expected %0d, got %0d", want.finished, got.finished);
				errors++;
			end
			if (got.end_time !== want.end_time) begin
				$error("end_time: expected %0d, got %0d", want.end_time, got.end_time);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic command;
	logic [7:0] job_id;
	logic [15:0] burst_length;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [7:0] served_id;
	logic served_level;
	logic [15:0] slice_length;
	logic job_finished;
	logic [31:0] end_time;

	slice_scoreboard sched;
	slice_t seen_slice;
	int send_gap_pct;
	int recv_idle_pct;
	int hold_left;
	int quiet_cycles;

	two_level_feedback_queue_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.job_id       (job_id),
		.burst_length (burst_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.served_id    (served_id),
		.served_level (served_level),
		.slice_length (slice_length),
		.job_finished (job_finished),
		.end_time     (end_time)
	);

	always #2 clk = ~clk;

	// Receiver: a long hold-off, when requested, overrides the random stalls.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			seen_slice.status   = status_t'(status);
			seen_slice.id       = served_id;
			seen_slice.level    = served_level;
			seen_slice.length   = slice_length;
			seen_slice.finished = job_finished;
			seen_slice.end_time = end_time;
			sched.check_slice(seen_slice);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_word(input logic cmd, input logic [7:0] id, input logic [15:0] burst);
		in_valid = 1'b0;
		while ($urandom_range(99) < send_gap_pct)
			@(negedge clk);
		command      = cmd;
		job_id       = id;
		burst_length = burst;
		in_valid     = 1'b1;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sched.note_word(cmd, id, burst);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_quantum(input logic idx, input logic [15:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {16'h0000, value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		sched.set_quantum(idx, value);
	endtask

	task automatic wait_drained();
		while (sched.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_quanta(input logic [15:0] q0, input logic [15:0] q1);
		wait_drained();
		write_quantum(REG_QUANTUM0, q0);
		write_quantum(REG_QUANTUM1, q1);
	endtask

	// Bursts are mostly within a few quanta so that jobs finish, demote and
	// circulate in level 1; the rest cover the full field.
	function automatic logic [15:0] pick_burst();
		int top;
		int r;
		top = 3 * ((sched.quantum_l0 > sched.quantum_l1) ? sched.quantum_l0 : sched.quantum_l1);
		if (top > 65535)
			top = 65535;
		if (top < 1)
			top = 1;
		r = $urandom_range(99);
		if (r < 5)
			return 16'hFFFF;
		else if (r < 10)
			return 16'd1;
		else if (r < 20)
			return 16'($urandom_range(65535));
		else
			return 16'($urandom_range(top, 1));
	endfunction

	// Runs of arrival-heavy words fill level 0 (and, once demoted, level 1);
	// dispatch-heavy runs drain both queues down to idle dispatches.
	task automatic run_traffic(input int words);
		int sent;
		int arrive_pct;
		int run_len;
		logic cmd;
		sent = 0;
		while (sent < words) begin
			case ($urandom_range(3))
				0: arrive_pct = 85;
				1: arrive_pct = 15;
				default: arrive_pct = 50;
			endcase
			run_len = $urandom_range(40, 8);
			for (int i = 0; i < run_len && sent < words; i++) begin
				cmd = ($urandom_range(99) < arrive_pct) ? CMD_ARRIVE : CMD_DISPATCH;
				send_word(cmd, 8'($urandom_range(255)), pick_burst());
				sent++;
			end
		end
	endtask

	initial begin
		sched         = new();
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		command       = CMD_ARRIVE;
		job_id        = '0;
		burst_length  = '0;
		send_gap_pct  = 0;
		recv_idle_pct = 0;
		hold_left     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset quanta of 8 and 16 apply here.
		send_word(CMD_DISPATCH, 8'hFF, 16'hFFFF);
		send_word(CMD_ARRIVE, 8'h00, 16'h0000);
		send_word(CMD_DISPATCH, 8'h00, 16'h0000);
		send_word(CMD_ARRIVE, 8'hFF, 16'hFFFF);
		send_word(CMD_ARRIVE, 8'hA5, 16'd8);
		send_word(CMD_ARRIVE, 8'h5A, 16'd9);
		send_word(CMD_ARRIVE, 8'h01, 16'd1);
		repeat (4) send_word(CMD_DISPATCH, 8'h00, 16'h0000);
		repeat (3) send_word(CMD_DISPATCH, 8'h00, 16'h0000);
		send_word(CMD_ARRIVE, 8'h02, 16'd17);
		send_word(CMD_DISPATCH, 8'h00, 16'h0000);

		// A zero level-0 quantum still serves each job but moves it on unchanged, unless its burst is zero.
		set_quanta(16'd0, 16'd16);
		send_word(CMD_ARRIVE, 8'h03, 16'd5);
		send_word(CMD_ARRIVE, 8'h04, 16'd0);
		repeat (4) send_word(CMD_DISPATCH, 8'h00, 16'h0000);

		send_gap_pct  = 25;
		recv_idle_pct = 50;
		set_quanta(16'd1, 16'd1);
		run_traffic(260);
		wait_drained();
		hold_left = HOLD_CYCLES;
		run_traffic(40);
		set_quanta(16'hFFFF, 16'hFFFF);
		run_traffic(280);

		send_gap_pct  = 50;
		recv_idle_pct = 25;
		set_quanta(16'd3, 16'd7);
		run_traffic(280);
		set_quanta(16'd1, 16'hFFFF);
		run_traffic(280);

		send_gap_pct  = 0;
		recv_idle_pct = 0;
		set_quanta(16'hFFFF, 16'd1);
		run_traffic(280);
		set_quanta(16'($urandom_range(64, 1)), 16'($urandom_range(64, 1)));
		run_traffic(280);

		wait_drained();
		repeat (10) @(posedge clk);
		if (sched.errors == 0 && sched.outstanding() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
